[rtl/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge once reset is released
`define FBPA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define FBPA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/fbpa_pkg.sv]
// constants, codes and helpers for the fixed block pool allocator
`default_nettype none

package fbpa_pkg;

   localparam int MAX_BLOCKS = 256;
   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = IDX_W + 1;

   localparam int BLOCK_COUNT_W = 9;
   localparam int BLOCK_BYTES_W = 16;
   localparam int ADDR_W = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_BYTES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOL_BASE = 2'd2;

   localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RESET = 9'd256;
   localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RESET = 16'd64;
   localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'd0;

   // clamp a written block count to 1..MAX_BLOCKS
   function automatic logic [CNT_W-1:0] eff_count(input logic [BLOCK_COUNT_W-1:0] value);
      logic [CNT_W-1:0] result;
      if (value == '0) begin
         result = CNT_W'(1);
      end else if (int'(value) > MAX_BLOCKS) begin
         result = CNT_W'(MAX_BLOCKS);
      end else begin
         result = CNT_W'(value);
      end
      return result;
   endfunction

   // a block size of zero acts as one
   function automatic logic [BLOCK_BYTES_W-1:0] eff_bytes(input logic [BLOCK_BYTES_W-1:0] value);
      logic [BLOCK_BYTES_W-1:0] result;
      result = (value == '0) ? BLOCK_BYTES_W'(1) : value;
      return result;
   endfunction

endpackage

`default_nettype wire

[rtl/fbpa_if.sv]
// request, response and register write channel interfaces
`default_nettype none

interface fbpa_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic [fbpa_pkg::ADDR_W-1:0] free_address;

   modport source(output valid, output req_type, output free_address, input ready);
   modport sink(input valid, input req_type, input free_address, output ready);
endinterface

interface fbpa_rsp_if;
   logic valid;
   logic ready;
   logic [fbpa_pkg::ADDR_W-1:0] block_address;
   logic [fbpa_pkg::STATUS_W-1:0] status;
   logic [fbpa_pkg::BLOCK_COUNT_W-1:0] blocks_free;

   modport source(output valid, output block_address, output status, output blocks_free,
                  input ready);
   modport sink(input valid, input block_address, input status, input blocks_free,
                output ready);
endinterface

interface fbpa_csr_if;
   logic valid;
   logic ready;
   logic [fbpa_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [fbpa_pkg::CSR_DATA_W-1:0] write_data;

   modport source(output valid, output reg_index, output write_data, input ready);
   modport sink(input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

[rtl/fixed_block_pool_allocator.sv]
// fixed block pool allocator: free index stack with shared add/subtract unit
//
//   channel    dir   beat contents
//   req_chan   in    req_type, free_address
//   rsp_chan   out   block_address, status, blocks_free
//   csr_chan   in    reg_index, write_data (always ready)
//
// allocate: stack read, multiply, add and output in turn; an empty stack goes straight to output
// free: subtract base, 32-step restoring divide on the shared 32-bit adder, check, output; below base goes to output
// one request in flight; req_chan ready only while idle, response held in its own register
// a new request is taken while the previous response still waits on rsp_chan
// reset: synchronous, stack reads as 0..count-1 through a low-water mark
`default_nettype none
`include "assert_macros.svh"

module fixed_block_pool_allocator (
   input wire logic clock,
   input wire logic reset,
   fbpa_req_if.sink req_chan,
   fbpa_rsp_if.source rsp_chan,
   fbpa_csr_if.sink csr_chan
);

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] ST_IDLE = 3'd0;
   localparam logic [STATE_W-1:0] ST_READ = 3'd1;
   localparam logic [STATE_W-1:0] ST_ADD = 3'd2;
   localparam logic [STATE_W-1:0] ST_SUB = 3'd3;
   localparam logic [STATE_W-1:0] ST_DIV = 3'd4;
   localparam logic [STATE_W-1:0] ST_CHECK = 3'd5;
   localparam logic [STATE_W-1:0] ST_FINISH = 3'd6;

   localparam int AW = fbpa_pkg::ADDR_W;
   localparam int BW = fbpa_pkg::BLOCK_BYTES_W;
   localparam int IW = fbpa_pkg::IDX_W;
   localparam int CW = fbpa_pkg::CNT_W;
   localparam int STEP_W = $clog2(AW);
   localparam int PROD_W = IW + BW;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [BW-1:0] bytes_ff, bytes_in;
   logic [AW-1:0] base_ff, base_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic [CW-1:0] low_mark_ff, low_mark_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] quot_ff, quot_in;
   logic [BW-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [AW-1:0] res_addr_ff, res_addr_in;
   logic [fbpa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;
   logic [fbpa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [fbpa_pkg::BLOCK_COUNT_W-1:0] rsp_free_ff, rsp_free_in;

   logic [IW-1:0] stack_mem [fbpa_pkg::MAX_BLOCKS];
   logic [IW-1:0] rd_data_ff;
   logic mem_we;
   logic [IW-1:0] mem_wdata;

   logic req_fire, csr_fire, rsp_load;
   logic [CW-1:0] depth_dec;
   logic [IW-1:0] top_pos;
   logic [IW-1:0] top_idx;
   logic [BW:0] trial;
   logic [AW-1:0] alu_a, alu_b;
   logic alu_sub;
   logic [AW:0] alu_res;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_fire = req_chan.valid & req_chan.ready;
   assign csr_fire = csr_chan.valid & csr_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.block_address = rsp_addr_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.blocks_free = rsp_free_ff;

   assign depth_dec = depth_ff - CW'(1);
   assign top_pos = depth_dec[IW-1:0];
   // entries below the low-water mark are untouched since the last refill
   assign top_idx = (depth_dec < low_mark_ff) ? top_pos : rd_data_ff;
   assign trial = {rem_ff, quot_ff[AW-1]};

   // shared adder/subtractor operand selection
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      alu_sub = 1'b0;
      case (state_ff)
         ST_ADD: begin
            alu_a = base_ff;
            alu_b = AW'(prod_ff);
         end
         ST_SUB: begin
            alu_a = addr_ff;
            alu_b = base_ff;
            alu_sub = 1'b1;
         end
         ST_DIV: begin
            alu_a = AW'(trial);
            alu_b = AW'(bytes_ff);
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      bytes_in = bytes_ff;
      base_in = base_ff;
      depth_in = depth_ff;
      low_mark_in = low_mark_ff;
      addr_in = addr_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      prod_in = prod_ff;
      res_addr_in = res_addr_ff;
      res_status_in = res_status_ff;
      mem_we = 1'b0;
      mem_wdata = quot_ff[IW-1:0];
      rsp_load = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               addr_in = req_chan.free_address;
               if (req_chan.req_type == fbpa_pkg::REQ_ALLOC) begin
                  if (depth_ff == '0) begin
                     res_addr_in = '0;
                     res_status_in = fbpa_pkg::ST_EMPTY;
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  state_in = ST_SUB;
               end
            end
         end
         ST_READ: begin
            prod_in = top_idx * bytes_ff;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            res_addr_in = alu_res[AW-1:0];
            res_status_in = fbpa_pkg::ST_OK;
            depth_in = depth_dec;
            if (depth_dec < low_mark_ff) begin
               low_mark_in = depth_dec;
            end
            state_in = ST_FINISH;
         end
         ST_SUB: begin
            res_addr_in = '0;
            if (alu_res[AW]) begin
               res_status_in = fbpa_pkg::ST_BADADDR;
               state_in = ST_FINISH;
            end else begin
               quot_in = alu_res[AW-1:0];
               rem_in = '0;
               step_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (alu_res[AW]) begin
               rem_in = trial[BW-1:0];
               quot_in = {quot_ff[AW-2:0], 1'b0};
            end else begin
               rem_in = alu_res[BW-1:0];
               quot_in = {quot_ff[AW-2:0], 1'b1};
            end
            step_in = step_ff + STEP_W'(1);
            if (&step_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rem_ff != '0 || quot_ff >= AW'(count_ff)) begin
               res_status_in = fbpa_pkg::ST_BADADDR;
            end else if (depth_ff >= count_ff) begin
               res_status_in = fbpa_pkg::ST_OVERFLOW;
            end else begin
               mem_we = 1'b1;
               depth_in = depth_ff + CW'(1);
               res_status_in = fbpa_pkg::ST_OK;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_fire) begin
         case (csr_chan.reg_index)
            fbpa_pkg::CSR_BLOCK_COUNT: begin
               count_in = fbpa_pkg::eff_count(csr_chan.write_data[fbpa_pkg::BLOCK_COUNT_W-1:0]);
               depth_in = count_in;
               low_mark_in = count_in;
            end
            fbpa_pkg::CSR_BLOCK_BYTES: begin
               bytes_in = fbpa_pkg::eff_bytes(csr_chan.write_data[BW-1:0]);
            end
            fbpa_pkg::CSR_POOL_BASE: begin
               base_in = csr_chan.write_data[AW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_addr_in = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in = rsp_free_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in = res_addr_ff;
         rsp_status_in = res_status_ff;
         rsp_free_in = fbpa_pkg::BLOCK_COUNT_W'(depth_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= fbpa_pkg::eff_count(fbpa_pkg::BLOCK_COUNT_RESET);
         bytes_ff <= fbpa_pkg::BLOCK_BYTES_RESET;
         base_ff <= fbpa_pkg::POOL_BASE_RESET;
         depth_ff <= fbpa_pkg::eff_count(fbpa_pkg::BLOCK_COUNT_RESET);
         low_mark_ff <= fbpa_pkg::eff_count(fbpa_pkg::BLOCK_COUNT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bytes_ff <= bytes_in;
         base_ff <= base_in;
         depth_ff <= depth_in;
         low_mark_ff <= low_mark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      res_addr_ff <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff <= rsp_free_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[depth_ff[IW-1:0]] <= mem_wdata;
      end
      rd_data_ff <= stack_mem[top_pos];
   end

   `FBPA_ASSERT(a_depth_le_count, (depth_ff <= count_ff), "stack depth above block count")
   `FBPA_ASSERT(a_mark_le_depth, (low_mark_ff <= depth_ff), "low-water mark above stack depth")
   `FBPA_ASSERT(a_push_has_room, (mem_we |-> depth_ff < count_ff), "push into a full stack")
   `FBPA_ASSERT(a_div_ends, (state_ff == ST_DIV && (&step_ff) |=> state_ff == ST_CHECK),
      "divide did not finish after last step")
   `FBPA_ASSERT_ALWAYS(a_ready_idle, (req_chan.ready |-> state_ff == ST_IDLE),
      "request ready outside idle")

endmodule

`default_nettype wire
